// ----- hw/rtl/waveform_column_bar_renderer_top_defines.svh -----
// Assertion macros shared by the renderer's checking code.
`ifndef WAVEFORM_COLUMN_BAR_RENDERER_TOP_DEFINES_SVH
`define WAVEFORM_COLUMN_BAR_RENDERER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet while in reset.
`define WCBR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wcbr check failed");

// Next-cycle implication, sampled on clk_i, quiet while in reset.
`define WCBR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wcbr check failed");

`endif

// ----- hw/rtl/wcbr_pkg.sv -----
// Shared constants, register indexes and controller/datapath bundles.
`default_nettype none

package wcbr_pkg;

  // Display geometry
  localparam int unsigned DISPLAY_HEIGHT = 8;
  localparam int unsigned DISPLAY_WIDTH  = 16;
  localparam int unsigned HALF_HEIGHT    = DISPLAY_HEIGHT / 2;

  // Field widths
  localparam int unsigned COL_W  = 4;
  localparam int unsigned ROW_W  = 3;
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned PEAK_W = 32;
  localparam int unsigned SPAN_W = 31;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned IDX_W  = 3;

  // Internal widths: column compares, row coordinate, divider
  localparam int unsigned CMP_W     = 10;
  localparam int unsigned Y_W       = 8;
  localparam int unsigned DIFF_W    = PEAK_W + 1;
  localparam int unsigned FRAC_W    = 24;
  localparam int unsigned DVD_W     = DIFF_W + FRAC_W;
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  // One display row and half a row in position units
  localparam logic [PEAK_W-1:0] ROW_ONE  = 32'd16777216;
  localparam logic [PEAK_W-1:0] ROW_HALF = 32'd8388608;

  // Brightness levels
  localparam logic [8:0] BRIGHT_COLOUR = 9'd256;
  localparam logic [8:0] BRIGHT_MONO   = 9'd128;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_CENTRE = 3'd0;
  localparam logic [IDX_W-1:0] REG_SPAN   = 3'd1;
  localparam logic [IDX_W-1:0] REG_COLOUR = 3'd2;
  localparam logic [IDX_W-1:0] REG_RED    = 3'd3;
  localparam logic [IDX_W-1:0] REG_GREEN  = 3'd4;
  localparam logic [IDX_W-1:0] REG_BLUE   = 3'd5;
  localparam logic [IDX_W-1:0] REG_MIRROR = 3'd6;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic adjust;
    logic bounds;
    logic amt;
    logic emit;
  } wcbr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_ok;
    logic no_rows;
    logic last;
    logic out_free;
  } wcbr_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/waveform_column_bar_renderer_top.sv -----
// Flow: a drawable column beat loads the 57-step serial divider pair; then the
// bar is widened if thin, its rows are clipped to the display, and each row
// passes an amount state and a pixel state, the pixel state holding while the
// output stalls. A bar that covers no row emits nothing; the input reopens
// after the last row. An invalid or off-display beat is taken and dropped.
// Reset: config registers return to defaults, controller idles, output empty.
`default_nettype none
`include "waveform_column_bar_renderer_top_defines.svh"

module waveform_column_bar_renderer_top import wcbr_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [IDX_W-1:0]         cfg_idx_i,
  input  wire logic [CFG_W-1:0]         cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [COL_W-1:0]         column_i,
  input  wire logic                     column_valid_i,
  input  wire logic signed [PEAK_W-1:0] peak_min_i,
  input  wire logic signed [PEAK_W-1:0] peak_max_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [COL_W-1:0]              out_column_o,
  output logic [ROW_W-1:0]              out_row_o,
  output logic [PIX_W-1:0]              pixel_red_o,
  output logic [PIX_W-1:0]              pixel_green_o,
  output logic [PIX_W-1:0]              pixel_blue_o,
  output logic                          last_row_o
);

  wcbr_cmd_t cmd;
  wcbr_sts_t sts;

  wcbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wcbr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .column_i       (column_i),
    .column_valid_i (column_valid_i),
    .peak_min_i     (peak_min_i),
    .peak_max_i     (peak_max_i),
    .out_stall_i    (out_stall_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_column_o   (out_column_o),
    .out_row_o      (out_row_o),
    .pixel_red_o    (pixel_red_o),
    .pixel_green_o  (pixel_green_o),
    .pixel_blue_o   (pixel_blue_o),
    .last_row_o     (last_row_o)
  );

  // A drawable column beat closes the input until its pixels are done
  `WCBR_ASSERT_NEXT(a_busy_after_take, in_valid_i && !in_stall_o && sts.in_ok, in_stall_o)

  // An emitted pixel shows up on the output next cycle
  `WCBR_ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid_o)

  // The last row of a column reopens the input
  `WCBR_ASSERT_NEXT(a_last_reopens, cmd.emit && sts.last, !in_stall_o)

  // Datapath commands other than divider steps never overlap
  `WCBR_ASSERT_NOW(a_cmd_exclusive, 1'b1,
                   $onehot0({cmd.load, cmd.adjust, cmd.bounds, cmd.amt, cmd.emit}))

endmodule

`default_nettype wire

// ----- hw/rtl/wcbr_div.sv -----
// Bit-serial restoring divider for one peak position.
`default_nettype none

module wcbr_div import wcbr_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     load_i,
  input  wire logic                     step_i,
  input  wire logic signed [DIFF_W-1:0] diff_i,
  input  wire logic [SPAN_W-1:0]        span_i,
  output logic [PEAK_W-1:0]             quot_o
);

  logic [SPAN_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0]  quo_q, quo_d;
  logic              neg_q, neg_d;
  logic [DIFF_W-1:0] mag;
  logic [SPAN_W:0]   trial;
  logic [SPAN_W:0]   trial_sub;
  logic              ge;

  // Magnitude of the difference; the load scales it by one row
  assign mag = diff_i[DIFF_W-1] ? DIFF_W'(-diff_i) : DIFF_W'(diff_i);

  // Shift in one dividend bit and try the divisor
  assign trial     = {rem_q, quo_q[DVD_W-1]};
  assign ge        = trial >= {1'b0, span_i};
  assign trial_sub = trial - {1'b0, span_i};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    neg_d = neg_q;
    if (load_i) begin
      rem_d = '0;
      quo_d = {mag, {FRAC_W{1'b0}}};
      neg_d = diff_i[DIFF_W-1];
    end else if (step_i) begin
      rem_d = ge ? trial_sub[SPAN_W-1:0] : trial[SPAN_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  // Restore the sign; keep the low word with wrap
  assign quot_o = neg_q ? PEAK_W'(-quo_q[PEAK_W-1:0]) : quo_q[PEAK_W-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/wcbr_dp.sv -----
// Datapath: config registers, two dividers, bar bounds and pixel shading.
`default_nettype none

module wcbr_dp import wcbr_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [IDX_W-1:0]         cfg_idx_i,
  input  wire logic [CFG_W-1:0]         cfg_wdata_i,
  input  wire logic [COL_W-1:0]         column_i,
  input  wire logic                     column_valid_i,
  input  wire logic signed [PEAK_W-1:0] peak_min_i,
  input  wire logic signed [PEAK_W-1:0] peak_max_i,
  input  wire logic                     out_stall_i,
  input  wire wcbr_cmd_t                cmd_i,
  output wcbr_sts_t                     sts_o,
  output logic                          out_valid_o,
  output logic [COL_W-1:0]              out_column_o,
  output logic [ROW_W-1:0]              out_row_o,
  output logic [PIX_W-1:0]              pixel_red_o,
  output logic [PIX_W-1:0]              pixel_green_o,
  output logic [PIX_W-1:0]              pixel_blue_o,
  output logic                          last_row_o
);

  localparam logic [CMP_W-1:0]      LAST_COL = CMP_W'(DISPLAY_WIDTH - 1);
  localparam logic [CMP_W-1:0]      NUM_COLS = CMP_W'(DISPLAY_WIDTH);
  localparam logic signed [Y_W-1:0] Y_MIN    = -Y_W'(HALF_HEIGHT);
  localparam logic signed [Y_W:0]   Y_LIMIT  = (Y_W + 1)'(HALF_HEIGHT);

  // Configuration registers
  logic signed [PEAK_W-1:0] centre_q;
  logic [SPAN_W-1:0]        span_q;
  logic                     colour_q;
  logic [PIX_W-1:0]         red_q, green_q, blue_q;
  logic                     mirror_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_q <= '0;
      span_q   <= SPAN_W'(ROW_ONE);
      colour_q <= 1'b0;
      red_q    <= '1;
      green_q  <= '1;
      blue_q   <= '1;
      mirror_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTRE: centre_q <= $signed(cfg_wdata_i);
        REG_SPAN:   span_q   <= cfg_wdata_i[SPAN_W-1:0];
        REG_COLOUR: colour_q <= cfg_wdata_i[0];
        REG_RED:    red_q    <= cfg_wdata_i[PIX_W-1:0];
        REG_GREEN:  green_q  <= cfg_wdata_i[PIX_W-1:0];
        REG_BLUE:   blue_q   <= cfg_wdata_i[PIX_W-1:0];
        REG_MIRROR: mirror_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Map the column and check it lands on the display
  logic [CMP_W-1:0] col_in, col_map;
  logic             col_ok;

  always_comb begin
    col_in  = CMP_W'(column_i);
    col_map = col_in;
    col_ok  = column_valid_i;
    if (mirror_q) begin
      if (col_in > LAST_COL) col_ok = 1'b0;
      col_map = LAST_COL - col_in;
    end
    if (col_map >= NUM_COLS) col_ok = 1'b0;
  end

  logic [COL_W-1:0] col_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) col_q <= col_map[COL_W-1:0];
  end

  // Peak offsets from the centre and the divisor
  logic signed [DIFF_W-1:0] diff_lo, diff_hi;
  logic [SPAN_W-1:0]        span_eff;
  logic [PEAK_W-1:0]        quot_lo, quot_hi;

  assign diff_lo  = {peak_min_i[PEAK_W-1], peak_min_i} - {centre_q[PEAK_W-1], centre_q};
  assign diff_hi  = {peak_max_i[PEAK_W-1], peak_max_i} - {centre_q[PEAK_W-1], centre_q};
  assign span_eff = (span_q == '0) ? SPAN_W'(1) : span_q;

  wcbr_div u_div_lo (
    .clk_i  (clk_i),
    .load_i (cmd_i.load),
    .step_i (cmd_i.div_step),
    .diff_i (diff_lo),
    .span_i (span_eff),
    .quot_o (quot_lo)
  );

  wcbr_div u_div_hi (
    .clk_i  (clk_i),
    .load_i (cmd_i.load),
    .step_i (cmd_i.div_step),
    .diff_i (diff_hi),
    .span_i (span_eff),
    .quot_o (quot_hi)
  );

  // Widen a bar thinner than one row about its midpoint
  logic [PEAK_W-1:0] span_hl, mid;
  logic              narrow;
  logic [PEAK_W-1:0] lo_q, hi_q;

  assign span_hl = quot_hi - quot_lo;
  assign narrow  = $signed(span_hl) < $signed(ROW_ONE);
  assign mid     = PEAK_W'($signed(quot_hi) >>> 1) + PEAK_W'($signed(quot_lo) >>> 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.adjust) begin
      lo_q <= narrow ? (mid - ROW_HALF) : quot_lo;
      hi_q <= narrow ? (mid + ROW_HALF) : quot_hi;
    end
  end

  // Row range clipped to the display
  logic signed [Y_W-1:0] ylo, yhi;
  logic signed [Y_W:0]   yhi_nx;
  logic signed [Y_W-1:0] ylo_q, yhi_q, y_q;
  logic signed [Y_W:0]   ystop_q;
  logic signed [Y_W:0]   y_nx;

  assign ylo    = $signed(lo_q[PEAK_W-1:PEAK_W-Y_W]);
  assign yhi    = $signed(hi_q[PEAK_W-1:PEAK_W-Y_W]);
  assign yhi_nx = {yhi[Y_W-1], yhi} + (Y_W + 1)'(1);
  assign y_nx   = {y_q[Y_W-1], y_q} + (Y_W + 1)'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.bounds) begin
      ylo_q   <= ylo;
      yhi_q   <= yhi;
      y_q     <= (ylo > Y_MIN) ? ylo : Y_MIN;
      ystop_q <= (yhi_nx < Y_LIMIT) ? yhi_nx : Y_LIMIT;
    end else if (cmd_i.emit) begin
      y_q <= y_nx[Y_W-1:0];
    end
  end

  // Edge-weighted amount for the current row, then squared
  logic [PIX_W-1:0] flo, fhi;
  logic [8:0]       b_lvl, wlo, whi, amount;
  logic [17:0]      amt_sq;
  logic [8:0]       v_q;

  assign flo   = lo_q[FRAC_W-1:FRAC_W-PIX_W];
  assign fhi   = hi_q[FRAC_W-1:FRAC_W-PIX_W];
  assign b_lvl = colour_q ? BRIGHT_COLOUR : BRIGHT_MONO;
  assign wlo   = colour_q ? {1'b0, flo} : {2'b00, flo[PIX_W-1:1]};
  assign whi   = colour_q ? {1'b0, fhi} : {2'b00, fhi[PIX_W-1:1]};

  always_comb begin
    if (y_q == ylo_q) begin
      amount = b_lvl - wlo;
    end else if (y_q < yhi_q) begin
      amount = b_lvl;
    end else begin
      amount = whi;
    end
  end

  assign amt_sq = amount * amount;

  always_ff @(posedge clk_i) begin
    if (cmd_i.amt) v_q <= amt_sq[16:8];
  end

  // Tint (in colour mode) and load the output register
  logic [16:0]      prod_r, prod_g, prod_b;
  logic [Y_W-1:0]   row_full;
  logic             out_valid_q;
  logic [COL_W-1:0] out_col_q;
  logic [ROW_W-1:0] out_row_q;
  logic [PIX_W-1:0] red_o_q, green_o_q, blue_o_q;
  logic             last_q;

  assign prod_r   = v_q * red_q;
  assign prod_g   = v_q * green_q;
  assign prod_b   = v_q * blue_q;
  assign row_full = y_q + Y_W'(HALF_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_col_q <= col_q;
      out_row_q <= row_full[ROW_W-1:0];
      red_o_q   <= colour_q ? prod_r[15:8] : v_q[PIX_W-1:0];
      green_o_q <= colour_q ? prod_g[15:8] : v_q[PIX_W-1:0];
      blue_o_q  <= colour_q ? prod_b[15:8] : v_q[PIX_W-1:0];
      last_q    <= (y_nx == ystop_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_column_o  = out_col_q;
  assign out_row_o     = out_row_q;
  assign pixel_red_o   = red_o_q;
  assign pixel_green_o = green_o_q;
  assign pixel_blue_o  = blue_o_q;
  assign last_row_o    = last_q;

  // Status back to the controller
  assign sts_o.in_ok    = col_ok;
  assign sts_o.no_rows  = $signed({y_q[Y_W-1], y_q}) >= ystop_q;
  assign sts_o.last     = (y_nx == ystop_q);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

// ----- hw/rtl/wcbr_ctrl.sv -----
// Controller: sequences division, bar setup and one pixel per row.
`default_nettype none

module wcbr_ctrl import wcbr_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire wcbr_sts_t sts_i,
  output wcbr_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_ADJ  = 3'd2;
  localparam logic [2:0] S_BND  = 3'd3;
  localparam logic [2:0] S_AMT  = 3'd4;
  localparam logic [2:0] S_PIX  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        // Take a beat; drop it here if it draws nothing
        if (in_valid_i && sts_i.in_ok) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = S_ADJ;
      end
      S_ADJ: begin
        cmd_o.adjust = 1'b1;
        state_d      = S_BND;
      end
      S_BND: begin
        cmd_o.bounds = 1'b1;
        state_d      = S_AMT;
      end
      S_AMT: begin
        if (sts_i.no_rows) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.amt = 1'b1;
          state_d   = S_PIX;
        end
      end
      S_PIX: begin
        // Hold until the output register can take the beat
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.last ? S_IDLE : S_AMT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire
